// ----- design/aocs_pkg.sv -----
// Shared types, codes and constants for the accelerometer offset calibration and smoothing block.
`timescale 1ns / 1ps

package aocs_pkg;

  localparam int NUM_AXES   = 3;
  localparam int AXIS_Z     = 2;
  localparam int CMD_W      = 2;
  localparam int RAW_W      = 16;
  localparam int ACCEL_W    = 16;
  localparam int SMOOTH_W   = 24;
  localparam int FILT_W     = 32;
  localparam int OFFS_W     = 17;
  localparam int ALPHA_W    = 16;
  localparam int ONE_G_W    = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CALIB   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_G_COUNTS = 1'd1;

  localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RESET = 16'd6554;
  localparam logic [ONE_G_W-1:0] ONE_G_COUNTS_RESET = 12'd256;

  localparam logic signed [ACCEL_W-1:0] ACCEL_MAX = {1'b0, {(ACCEL_W-1){1'b1}}};
  localparam logic signed [ACCEL_W-1:0] ACCEL_MIN = {1'b1, {(ACCEL_W-1){1'b0}}};

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } sample_t;

  typedef struct packed {
    logic signed [ACCEL_W-1:0]  accel_x;
    logic signed [ACCEL_W-1:0]  accel_y;
    logic signed [ACCEL_W-1:0]  accel_z;
    logic signed [SMOOTH_W-1:0] smooth_x;
    logic signed [SMOOTH_W-1:0] smooth_y;
    logic signed [SMOOTH_W-1:0] smooth_z;
    logic                       calibrating;
    logic                       calib_done;
  } result_t;

  // clamp an offset-corrected count to the 16-bit output range
  function automatic logic signed [ACCEL_W-1:0] sat_accel(input logic signed [OFFS_W:0] v);
    logic [OFFS_W-ACCEL_W+1:0] top;
    top = v[OFFS_W:ACCEL_W-1];
    if (top == '0 || top == '1) begin
      sat_accel = v[ACCEL_W-1:0];
    end else if (v[OFFS_W]) begin
      sat_accel = ACCEL_MIN;
    end else begin
      sat_accel = ACCEL_MAX;
    end
  endfunction

endpackage

// ----- design/aocs_stream_if.sv -----
// Valid/ready stream channel carrying one payload per transfer.
`timescale 1ns / 1ps

interface aocs_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/accel_offset_calibrate_smooth.sv -----
// Top level: three-axis offset calibration with per-axis exponential smoothing.
// Takes one item per clock unless the output stalls, and returns one result per item
// through the input register, then the result register; all per-item work is
// combinational between them. A measure item subtracts the stored offsets (saturated) and
// updates each axis filter with one alpha multiply and one (1 - alpha) multiply. A
// calibrate item accumulates raw counts; on the CALIB_SAMPLES-th one the offsets load
// with the sums divided by CALIB_SAMPLES (reciprocal multiply, truncated toward zero),
// one_g_counts taken off Z. A clear item zeroes offsets, filters and any partial run.
// The next item sees the state left by the previous one with no bubble; the input
// keeps flowing while a result waits at the output, until both registers are full.
`timescale 1ns / 1ps

module accel_offset_calibrate_smooth #(
  parameter int CALIB_SAMPLES = 100
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [aocs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aocs_pkg::CFG_DATA_W-1:0]     cfg_data,
  aocs_stream_if.sink                         sample,
  aocs_stream_if.source                       result
);

  localparam int NUM_AXES  = aocs_pkg::NUM_AXES;
  localparam int RAW_W     = aocs_pkg::RAW_W;
  localparam int ACCEL_W   = aocs_pkg::ACCEL_W;
  localparam int SMOOTH_W  = aocs_pkg::SMOOTH_W;
  localparam int FILT_W    = aocs_pkg::FILT_W;
  localparam int OFFS_W    = aocs_pkg::OFFS_W;
  localparam int ALPHA_W   = aocs_pkg::ALPHA_W;
  localparam int ONE_G_W   = aocs_pkg::ONE_G_W;

  localparam int CNT_W     = $clog2(CALIB_SAMPLES + 1);
  localparam int SUM_W     = RAW_W + 1 + $clog2(CALIB_SAMPLES);
  localparam int DIV_SHIFT = SUM_W - 1 + $clog2(CALIB_SAMPLES);
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int OLDP_W    = ALPHA_W + 2 + FILT_W;
  localparam int NEWP_W    = ALPHA_W + 1 + ACCEL_W;

  localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(CALIB_SAMPLES);
  // ceil(2^DIV_SHIFT / N): exact floor divide for every reachable sum magnitude
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(
      ((64'd1 << DIV_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

  // configuration
  logic [ALPHA_W-1:0] filter_alpha;
  logic [ONE_G_W-1:0] one_g_counts;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_alpha <= aocs_pkg::FILTER_ALPHA_RESET;
      one_g_counts <= aocs_pkg::ONE_G_COUNTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        aocs_pkg::REG_FILTER_ALPHA: filter_alpha <= cfg_data[ALPHA_W-1:0];
        aocs_pkg::REG_ONE_G_COUNTS: one_g_counts <= cfg_data[ONE_G_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: input register and result register
  logic              stage_valid;
  aocs_pkg::sample_t stage;
  logic              out_valid;
  aocs_pkg::result_t out_item;
  aocs_pkg::result_t out_next;
  logic              advance;

  assign advance       = stage_valid && (!out_valid || result.ready);
  assign sample.ready  = !stage_valid || advance;
  assign result.valid  = out_valid;
  assign result.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample.ready) begin
      stage_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      stage <= sample.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= out_next;
    end
  end

  // state
  logic signed [OFFS_W-1:0] offset      [NUM_AXES];
  logic signed [FILT_W-1:0] filter      [NUM_AXES];
  logic signed [SUM_W-1:0]  calib_sum   [NUM_AXES];
  logic [CNT_W-1:0]         calib_count;

  logic signed [OFFS_W-1:0] offset_next [NUM_AXES];
  logic signed [FILT_W-1:0] filter_next [NUM_AXES];
  logic signed [SUM_W-1:0]  sum_next    [NUM_AXES];
  logic [CNT_W-1:0]         count_next;

  // control
  logic             cmd_measure;
  logic             cmd_calib;
  logic             cmd_clear;
  logic             done;
  logic [CNT_W-1:0] count_inc;

  always_comb begin
    cmd_measure = stage.cmd == aocs_pkg::CMD_MEASURE;
    cmd_calib   = stage.cmd == aocs_pkg::CMD_CALIB;
    cmd_clear   = stage.cmd == aocs_pkg::CMD_CLEAR;
    count_inc   = calib_count + CNT_W'(1);
    done        = cmd_calib && (count_inc == CNT_LAST);
    if (cmd_clear) begin
      count_next = '0;
    end else if (cmd_calib) begin
      count_next = done ? '0 : count_inc;
    end else begin
      count_next = calib_count;
    end
  end

  logic [ALPHA_W:0] w_old;
  assign w_old = {1'b1, {ALPHA_W{1'b0}}} - {1'b0, filter_alpha};

  // per-axis datapath
  logic signed [RAW_W-1:0]   raw       [NUM_AXES];
  logic signed [ACCEL_W-1:0] accel_new [NUM_AXES];

  assign raw[0] = stage.raw_x;
  assign raw[1] = stage.raw_y;
  assign raw[2] = stage.raw_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [SUM_W-1:0]   sum_add;
    logic [SUM_W-1:0]          mag;
    logic [PROD_W-1:0]         prod;
    logic [OFFS_W-1:0]         quot_mag;
    logic signed [OFFS_W-1:0]  quot;
    logic signed [OFFS_W-1:0]  load_val;
    logic signed [ACCEL_W-1:0] accel_cur;
    logic signed [OLDP_W-1:0]  old_prod;
    logic signed [NEWP_W-1:0]  new_prod;
    logic signed [FILT_W-1:0]  filt_upd;

    always_comb begin
      sum_add  = calib_sum[a] + SUM_W'(raw[a]);
      mag      = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);
      prod     = PROD_W'(mag) * PROD_W'(DIV_RECIP);
      quot_mag = prod[DIV_SHIFT +: OFFS_W];
      quot     = sum_add[SUM_W-1] ? -$signed(quot_mag) : $signed(quot_mag);
    end

    if (a == aocs_pkg::AXIS_Z) begin : g_z
      assign load_val = quot - $signed({{(OFFS_W-ONE_G_W){1'b0}}, one_g_counts});
    end else begin : g_xy
      assign load_val = quot;
    end

    always_comb begin
      accel_cur = aocs_pkg::sat_accel((OFFS_W+1)'(raw[a]) - (OFFS_W+1)'(offset[a]));
      old_prod  = $signed({1'b0, w_old}) * filter[a];
      new_prod  = $signed({1'b0, filter_alpha}) * accel_cur;
      filt_upd  = new_prod[FILT_W-1:0] + old_prod[ALPHA_W +: FILT_W];

      if (cmd_clear) begin
        offset_next[a] = '0;
        filter_next[a] = '0;
        sum_next[a]    = '0;
      end else if (cmd_calib) begin
        offset_next[a] = done ? load_val : offset[a];
        filter_next[a] = filter[a];
        sum_next[a]    = done ? '0 : sum_add;
      end else if (cmd_measure) begin
        offset_next[a] = offset[a];
        filter_next[a] = filt_upd;
        sum_next[a]    = calib_sum[a];
      end else begin
        offset_next[a] = offset[a];
        filter_next[a] = filter[a];
        sum_next[a]    = calib_sum[a];
      end

      accel_new[a] = aocs_pkg::sat_accel((OFFS_W+1)'(raw[a]) - (OFFS_W+1)'(offset_next[a]));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        offset[a]    <= '0;
        filter[a]    <= '0;
        calib_sum[a] <= '0;
      end else if (advance) begin
        offset[a]    <= offset_next[a];
        filter[a]    <= filter_next[a];
        calib_sum[a] <= sum_next[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_count <= '0;
    end else if (advance) begin
      calib_count <= count_next;
    end
  end

  always_comb begin
    out_next.accel_x     = accel_new[0];
    out_next.accel_y     = accel_new[1];
    out_next.accel_z     = accel_new[2];
    out_next.smooth_x    = filter_next[0][FILT_W-1 -: SMOOTH_W];
    out_next.smooth_y    = filter_next[1][FILT_W-1 -: SMOOTH_W];
    out_next.smooth_z    = filter_next[2][FILT_W-1 -: SMOOTH_W];
    out_next.calibrating = count_next != '0;
    out_next.calib_done  = done;
  end

`ifndef SYNTHESIS
  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.payload.calib_done && result.payload.calibrating))
    else $error("calibration done reported with a run still open");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    calib_count < CNT_LAST)
    else $error("calibration count reached the run length");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (advance && cmd_clear) |=> (calib_count == '0 && filter[0] == '0 &&
                                filter[1] == '0 && filter[2] == '0 && offset[2] == '0))
    else $error("clear transfer left state behind");

  a_calib_counts: assert property (@(posedge clk) disable iff (rst)
    (advance && cmd_calib && !done) |=> (calib_count == $past(calib_count) + CNT_W'(1)))
    else $error("calibration sample not counted");
`endif

endmodule
